@@ hw/rtl/sbc_pkg.sv @@
// Shared types, codes and defaults for the sparse boolean CSR matrix block.
package sbc_pkg;

    localparam int MAX_ROWS_DEF    = 1024;
    localparam int MAX_ENTRIES_DEF = 4096;
    localparam int DIMENSION_DEF   = 4096;

    localparam int ROW_W       = 12;
    localparam int COL_W       = 12;
    localparam int WORD_IDX_W  = 6;
    localparam int WORD_W      = 64;
    localparam int BIT_SEL_W   = 6;
    localparam int BITMAP_WORDS = 64;

    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_FINISH = 3'd1,
        ACT_TEST   = 3'd2,
        ACT_ACCUM  = 3'd3,
        ACT_READ   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_ORDER = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_START,
        S_END,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_OR,
        S_RD_WAIT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        BM_NONE,
        BM_READ,
        BM_OR,
        BM_CLEAR
    } bm_op_t;

    typedef struct packed {
        bm_op_t                  op;
        logic [WORD_IDX_W-1:0]   word;
        logic [BIT_SEL_W-1:0]    bit_sel;
    } bm_cmd_t;

endpackage

@@ hw/rtl/sbc_in_if.sv @@
// Input channel carrying one matrix transaction.
interface sbc_in_if;
    logic                               valid;
    logic                               ready;
    logic [2:0]                         action;
    logic [sbc_pkg::ROW_W-1:0]          row;
    logic [sbc_pkg::COL_W-1:0]          col;
    logic [sbc_pkg::WORD_IDX_W-1:0]     word_index;

    modport source (output valid, action, row, col, word_index, input ready);
    modport sink   (input valid, action, row, col, word_index, output ready);
endinterface

@@ hw/rtl/sbc_out_if.sv @@
// Output channel carrying one result transaction.
interface sbc_out_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [sbc_pkg::WORD_W-1:0]     word_data;
    logic [1:0]                     status;

    modport source (output valid, hit, word_data, status, input ready);
    modport sink   (input valid, hit, word_data, status, output ready);
endinterface

@@ hw/rtl/sbc_bitmap.sv @@
// Result bitmap memory with per-word valid bits, read, OR-set and clear.
module sbc_bitmap (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sbc_pkg::bm_cmd_t                cmd,
    output logic [sbc_pkg::WORD_W-1:0]      rdata
);

    logic [sbc_pkg::WORD_W-1:0]         mem [0:sbc_pkg::BITMAP_WORDS-1];
    logic [sbc_pkg::BITMAP_WORDS-1:0]   valid_reg;
    logic [sbc_pkg::WORD_W-1:0]         rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                sbc_pkg::BM_OR:    valid_reg[cmd.word] <= 1'b1;
                sbc_pkg::BM_CLEAR: valid_reg[cmd.word] <= 1'b0;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            sbc_pkg::BM_READ:
            begin
                rdata_reg <= valid_reg[cmd.word] ? mem[cmd.word] : '0;
            end
            sbc_pkg::BM_OR:
            begin
                mem[cmd.word] <= rdata_reg
                               | (sbc_pkg::WORD_W'(1) << cmd.bit_sel);
            end
            default: ;
        endcase
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/sparse_boolean_csr_matrix_top.sv @@
// Top level: CSR storage, row binary search and row scan sequencer.
// Append, finish and unused actions go from dispatch straight to done; read loads the
// bitmap word and clears it; test and accumulate binary-search the row, read its start
// and end, then scan the column entries of the row (accumulate ORs each into the bitmap).
// Throughput: one transaction at a time; the next is taken once the result
// moves to the output register. Reset empties the matrix and result bitmap.
module sparse_boolean_csr_matrix_top #(
    parameter int MAX_ROWS    = sbc_pkg::MAX_ROWS_DEF,
    parameter int MAX_ENTRIES = sbc_pkg::MAX_ENTRIES_DEF,
    parameter int DIMENSION   = sbc_pkg::DIMENSION_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sbc_in_if.sink      item_in,
    sbc_out_if.source   result_out
);

    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ECW = $clog2(MAX_ENTRIES + 1);
    localparam int BM_WORDS = (DIMENSION + 63) / 64;

    sbc_pkg::state_t state_reg, state_next;

    logic [2:0]                         act_reg;
    logic [sbc_pkg::ROW_W-1:0]          row_reg;
    logic [sbc_pkg::COL_W-1:0]          col_reg;
    logic [sbc_pkg::WORD_IDX_W-1:0]     widx_reg;

    logic [RCW-1:0]                     rows_used_reg;
    logic [ECW-1:0]                     entries_used_reg;
    logic [sbc_pkg::ROW_W-1:0]          prev_row_reg;
    logic                               have_prev_reg;

    logic [RCW-1:0]                     lo_reg, hi_reg, mid_reg, p_reg;
    logic [RCW-1:0]                     mid_c;
    logic [ECW-1:0]                     k_reg, end_reg;

    logic                               hit_reg;
    logic [sbc_pkg::WORD_W-1:0]         data_reg;
    logic [1:0]                         status_reg;
    logic                               out_valid_reg;
    logic                               out_hit_reg;
    logic [sbc_pkg::WORD_W-1:0]         out_data_reg;
    logic [1:0]                         out_status_reg;

    logic [sbc_pkg::ROW_W-1:0]          rn_mem [0:MAX_ROWS-1];
    logic [ECW-1:0]                     rs_mem [0:MAX_ROWS];
    logic [sbc_pkg::COL_W-1:0]          ce_mem [0:MAX_ENTRIES-1];
    logic [sbc_pkg::ROW_W-1:0]          rn_q;
    logic [ECW-1:0]                     rs_q;
    logic [sbc_pkg::COL_W-1:0]          ce_q;

    logic                               rn_we, rs_we, ce_we;
    logic [RCW-1:0]                     rs_waddr, rs_raddr;
    logic [RCW-1:0]                     rn_raddr;
    logic [EIW-1:0]                     ce_raddr;

    sbc_pkg::bm_cmd_t                   bm_cmd;
    logic [sbc_pkg::WORD_W-1:0]         bm_rdata;

    logic                               accept;
    logic                               load_out;
    logic                               new_row;
    logic [1:0]                         app_status;
    logic                               col_in_range;
    logic                               word_in_range;
    logic                               last_row;

    assign accept   = item_in.valid && item_in.ready;
    assign load_out = (state_reg == sbc_pkg::S_DONE)
                   && (!out_valid_reg || result_out.ready);

    assign mid_c         = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign col_in_range  = {20'd0, col_reg} < 32'(DIMENSION);
    assign word_in_range = {26'd0, widx_reg} < 32'(BM_WORDS);
    assign last_row      = (p_reg + RCW'(1)) >= rows_used_reg;
    assign new_row       = !have_prev_reg || (prev_row_reg != row_reg);

    always_comb
    begin
        if (have_prev_reg && (row_reg < prev_row_reg))
            app_status = sbc_pkg::STAT_ORDER;
        else if (!col_in_range)
            app_status = sbc_pkg::STAT_FULL;
        else if (entries_used_reg == ECW'(MAX_ENTRIES))
            app_status = sbc_pkg::STAT_FULL;
        else if (new_row && (rows_used_reg == RCW'(MAX_ROWS)))
            app_status = sbc_pkg::STAT_FULL;
        else
            app_status = sbc_pkg::STAT_OK;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbc_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = sbc_pkg::S_DISPATCH;
            end
            sbc_pkg::S_DISPATCH:
            begin
                case (act_reg)
                    sbc_pkg::ACT_TEST:
                        state_next = col_in_range ? sbc_pkg::S_SRCH_RD : sbc_pkg::S_DONE;
                    sbc_pkg::ACT_ACCUM:
                        state_next = sbc_pkg::S_SRCH_RD;
                    sbc_pkg::ACT_READ:
                        state_next = word_in_range ? sbc_pkg::S_RD_WAIT : sbc_pkg::S_DONE;
                    default:
                        state_next = sbc_pkg::S_DONE;
                endcase
            end
            sbc_pkg::S_SRCH_RD:
                state_next = (lo_reg < hi_reg) ? sbc_pkg::S_SRCH_CMP : sbc_pkg::S_DONE;
            sbc_pkg::S_SRCH_CMP:
                state_next = (rn_q == row_reg) ? sbc_pkg::S_START : sbc_pkg::S_SRCH_RD;
            sbc_pkg::S_START:
                state_next = sbc_pkg::S_END;
            sbc_pkg::S_END:
                state_next = sbc_pkg::S_SCAN_RD;
            sbc_pkg::S_SCAN_RD:
                state_next = (k_reg < end_reg) ? sbc_pkg::S_SCAN_CHK : sbc_pkg::S_DONE;
            sbc_pkg::S_SCAN_CHK:
            begin
                if (act_reg == sbc_pkg::ACT_ACCUM)
                    state_next = sbc_pkg::S_SCAN_OR;
                else if (ce_q == col_reg)
                    state_next = sbc_pkg::S_DONE;
                else
                    state_next = sbc_pkg::S_SCAN_RD;
            end
            sbc_pkg::S_SCAN_OR:
                state_next = sbc_pkg::S_SCAN_RD;
            sbc_pkg::S_RD_WAIT:
                state_next = sbc_pkg::S_DONE;
            sbc_pkg::S_DONE:
            begin
                if (load_out)
                    state_next = sbc_pkg::S_IDLE;
            end
            default:
                state_next = sbc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        item_in.ready  = (state_reg == sbc_pkg::S_IDLE);
        rn_we          = 1'b0;
        rs_we          = 1'b0;
        ce_we          = 1'b0;
        rs_waddr       = rows_used_reg;
        rn_raddr       = mid_c;
        rs_raddr       = mid_reg;
        ce_raddr       = k_reg[EIW-1:0];
        bm_cmd.op      = sbc_pkg::BM_NONE;
        bm_cmd.word    = widx_reg;
        bm_cmd.bit_sel = ce_q[sbc_pkg::BIT_SEL_W-1:0];
        case (state_reg)
            sbc_pkg::S_DISPATCH:
            begin
                if (act_reg == sbc_pkg::ACT_APPEND && app_status == sbc_pkg::STAT_OK)
                begin
                    rn_we = new_row;
                    rs_we = new_row;
                    ce_we = 1'b1;
                end
                if (act_reg == sbc_pkg::ACT_FINISH)
                    rs_we = 1'b1;
                if (act_reg == sbc_pkg::ACT_READ && word_in_range)
                    bm_cmd.op = sbc_pkg::BM_READ;
            end
            sbc_pkg::S_START:
                rs_raddr = p_reg + RCW'(1);
            sbc_pkg::S_SCAN_CHK:
            begin
                bm_cmd.word = ce_q[sbc_pkg::COL_W-1:sbc_pkg::BIT_SEL_W];
                if (act_reg == sbc_pkg::ACT_ACCUM)
                    bm_cmd.op = sbc_pkg::BM_READ;
            end
            sbc_pkg::S_SCAN_OR:
            begin
                bm_cmd.word = ce_q[sbc_pkg::COL_W-1:sbc_pkg::BIT_SEL_W];
                bm_cmd.op   = sbc_pkg::BM_OR;
            end
            sbc_pkg::S_RD_WAIT:
                bm_cmd.op = sbc_pkg::BM_CLEAR;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rn_we)
            rn_mem[rows_used_reg[RIW-1:0]] <= row_reg;
        rn_q <= rn_mem[rn_raddr[RIW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
            rs_mem[rs_waddr] <= entries_used_reg;
        rs_q <= rs_mem[rs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ce_we)
            ce_mem[entries_used_reg[EIW-1:0]] <= col_reg;
        ce_q <= ce_mem[ce_raddr];
    end

    sbc_bitmap u_bitmap (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (bm_cmd),
        .rdata (bm_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sbc_pkg::S_IDLE;
            rows_used_reg    <= '0;
            entries_used_reg <= '0;
            prev_row_reg     <= '0;
            have_prev_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == sbc_pkg::S_DISPATCH && act_reg == sbc_pkg::ACT_APPEND
                && app_status == sbc_pkg::STAT_OK)
            begin
                entries_used_reg <= entries_used_reg + ECW'(1);
                if (new_row)
                begin
                    rows_used_reg <= rows_used_reg + RCW'(1);
                    prev_row_reg  <= row_reg;
                    have_prev_reg <= 1'b1;
                end
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= item_in.action;
            row_reg  <= item_in.row;
            col_reg  <= item_in.col;
            widx_reg <= item_in.word_index;
        end
        if (load_out)
        begin
            out_hit_reg    <= hit_reg;
            out_data_reg   <= data_reg;
            out_status_reg <= status_reg;
        end
        case (state_reg)
            sbc_pkg::S_DISPATCH:
            begin
                hit_reg    <= 1'b0;
                data_reg   <= '0;
                status_reg <= (act_reg == sbc_pkg::ACT_APPEND) ? app_status
                                                               : sbc_pkg::STAT_OK;
                lo_reg     <= '0;
                hi_reg     <= rows_used_reg;
            end
            sbc_pkg::S_SRCH_RD:
                mid_reg <= mid_c;
            sbc_pkg::S_SRCH_CMP:
            begin
                if (rn_q == row_reg)
                    p_reg <= mid_reg;
                else if (rn_q < row_reg)
                    lo_reg <= mid_reg + RCW'(1);
                else
                    hi_reg <= mid_reg;
            end
            sbc_pkg::S_START:
                k_reg <= rs_q;
            sbc_pkg::S_END:
                end_reg <= last_row ? entries_used_reg : rs_q;
            sbc_pkg::S_SCAN_CHK:
            begin
                if (act_reg != sbc_pkg::ACT_ACCUM)
                begin
                    if (ce_q == col_reg)
                        hit_reg <= 1'b1;
                    k_reg <= k_reg + ECW'(1);
                end
            end
            sbc_pkg::S_SCAN_OR:
                k_reg <= k_reg + ECW'(1);
            sbc_pkg::S_RD_WAIT:
                data_reg <= bm_rdata;
            default: ;
        endcase
    end

    assign result_out.valid     = out_valid_reg;
    assign result_out.hit       = out_hit_reg;
    assign result_out.word_data = out_data_reg;
    assign result_out.status    = out_status_reg;

    a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entries_used_reg <= ECW'(MAX_ENTRIES))
        else $error("entry count beyond store depth");

    a_rows_le_entries: assert property (@(posedge clk) disable iff (!rst_n)
        {{(32-RCW){1'b0}}, rows_used_reg} <= {{(32-ECW){1'b0}}, entries_used_reg})
        else $error("row without entries");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sbc_pkg::S_SCAN_CHK |-> $past(k_reg < end_reg))
        else $error("scan past row end");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == sbc_pkg::S_DISPATCH)
        else $error("accepted transaction not dispatched");

endmodule

@@ tb/tb_top.sv @@
// Testbench for the sparse boolean CSR matrix: directed and random transactions, scoreboard check.
`timescale 1ns / 1ps

module tb_top;

    localparam int ROWS_CAP    = sbc_pkg::MAX_ROWS_DEF;
    localparam int ENTRIES_CAP = sbc_pkg::MAX_ENTRIES_DEF;
    localparam int DIM         = sbc_pkg::DIMENSION_DEF;
    localparam int WORDS       = (DIM + 63) / 64;

    typedef struct {
        logic                       hit;
        logic [sbc_pkg::WORD_W-1:0] word_data;
        logic [1:0]                 status;
    } matrix_result_t;

    logic clk;
    logic rst_n;

    sbc_in_if  item_if ();
    sbc_out_if result_if ();

    sparse_boolean_csr_matrix_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (result_if)
    );

    // Shadow copy of the matrix
    logic [sbc_pkg::ROW_W-1:0]  shadow_row_nums [ROWS_CAP];
    int                         shadow_row_starts [ROWS_CAP + 1];
    logic [sbc_pkg::COL_W-1:0]  shadow_cols [ENTRIES_CAP];
    bit                         shadow_seen [DIM];
    logic [sbc_pkg::WORD_W-1:0] shadow_bitmap [WORDS];
    int                         rows_used;
    int                         entries_used;
    int                         last_row;
    bit                         have_last_row;

    matrix_result_t    pending_results[$];
    int                errors;
    int                items_sent;
    int                results_seen;
    int                full_drops;
    int                order_drops;
    int                hits_seen;
    bit                idle_enable;
    int                row_left;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic int find_row(int r);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = rows_used;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (shadow_row_nums[mid] == r)
                return mid;
            if (shadow_row_nums[mid] < r)
                lo = mid + 1;
            else
                hi = mid;
        end
        return rows_used;
    endfunction

    function automatic int row_stop(int p);
        return (p + 1 < rows_used) ? shadow_row_starts[p + 1] : entries_used;
    endfunction

    function automatic matrix_result_t predict_matrix(logic [2:0] act, int r, int c, int w);
        matrix_result_t res;
        bit             new_row;
        int             p;
        int             k;
        int             stop;
        res.hit = 1'b0;
        res.word_data = '0;
        res.status = sbc_pkg::STAT_OK;
        case (act)
            sbc_pkg::ACT_APPEND:
            begin
                new_row = !have_last_row || last_row != r;
                if (have_last_row && r < last_row)
                    res.status = sbc_pkg::STAT_ORDER;
                else if (c >= DIM || entries_used >= ENTRIES_CAP
                         || (new_row && rows_used >= ROWS_CAP))
                    res.status = sbc_pkg::STAT_FULL;
                else
                begin
                    if (new_row)
                    begin
                        shadow_row_nums[rows_used] = sbc_pkg::ROW_W'(r);
                        shadow_row_starts[rows_used] = entries_used;
                        rows_used++;
                        have_last_row = 1'b1;
                        last_row = r;
                    end
                    shadow_cols[entries_used] = sbc_pkg::COL_W'(c);
                    entries_used++;
                    shadow_seen[c] = 1'b1;
                end
            end
            sbc_pkg::ACT_FINISH:
                shadow_row_starts[rows_used] = entries_used;
            sbc_pkg::ACT_TEST:
            begin
                if (c < DIM && shadow_seen[c])
                begin
                    p = find_row(r);
                    if (p < rows_used)
                    begin
                        stop = row_stop(p);
                        for (k = shadow_row_starts[p]; k < stop && k < ENTRIES_CAP; k++)
                            if (shadow_cols[k] == c)
                                res.hit = 1'b1;
                    end
                end
            end
            sbc_pkg::ACT_ACCUM:
            begin
                p = find_row(r);
                if (p < rows_used)
                begin
                    stop = row_stop(p);
                    for (k = shadow_row_starts[p]; k < stop && k < ENTRIES_CAP; k++)
                        shadow_bitmap[shadow_cols[k][sbc_pkg::COL_W-1:sbc_pkg::BIT_SEL_W]]
                                     [shadow_cols[k][sbc_pkg::BIT_SEL_W-1:0]] = 1'b1;
                end
            end
            sbc_pkg::ACT_READ:
            begin
                if (w < WORDS)
                begin
                    res.word_data = shadow_bitmap[w];
                    shadow_bitmap[w] = '0;
                end
            end
            default:
                ;
        endcase
        return res;
    endfunction

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_item(logic [2:0] act, int r, int c, int w);
        int             gap;
        matrix_result_t exp_res;
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_if.valid      <= 1'b1;
        item_if.action     <= act;
        item_if.row        <= r[sbc_pkg::ROW_W-1:0];
        item_if.col        <= c[sbc_pkg::COL_W-1:0];
        item_if.word_index <= w[sbc_pkg::WORD_IDX_W-1:0];
        do
            @(posedge clk);
        while (!item_if.ready);
        exp_res = predict_matrix(act, r & 12'hFFF, c & 12'hFFF, w & 6'h3F);
        pending_results = {pending_results, exp_res};
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_append_run(int count);
        int i;
        int step;
        for (i = 0; i < count; i++)
        begin
            if (row_left == 0 || !have_last_row)
            begin
                step = (last_row + (ROWS_CAP - rows_used) * 2 > 4000) ? 1
                                                                      : $urandom_range(1, 3);
                row_left = $urandom_range(1, 4);
                send_item(sbc_pkg::ACT_APPEND,
                          have_last_row ? last_row + step : $urandom_range(0, 3),
                          $urandom_range(0, DIM - 1), $urandom_range(0, 63));
            end
            else
                send_item(sbc_pkg::ACT_APPEND, last_row, $urandom_range(0, DIM - 1),
                          $urandom_range(0, 63));
            row_left--;
        end
    endtask

    task automatic send_query();
        int idx;
        int c;
        int pick;
        pick = $urandom_range(0, 99);
        if (rows_used > 0 && pick < 60)
        begin
            idx = $urandom_range(0, rows_used - 1);
            c = (pick < 40) ? shadow_cols[$urandom_range(shadow_row_starts[idx],
                                                           row_stop(idx) - 1)]
                            : $urandom_range(0, DIM - 1);
            send_item(pick < 50 ? sbc_pkg::ACT_TEST : sbc_pkg::ACT_ACCUM,
                      shadow_row_nums[idx], c, $urandom_range(0, 63));
        end
        else if (pick < 80)
            send_item(sbc_pkg::ACT_READ, $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 63));
        else
            send_item(pick < 90 ? sbc_pkg::ACT_TEST : sbc_pkg::ACT_ACCUM,
                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 63));
    endtask

    task automatic test_empty_matrix();
        send_item(sbc_pkg::ACT_TEST, 0, 0, 0);
        send_item(sbc_pkg::ACT_ACCUM, 4095, 4095, 0);
        send_item(sbc_pkg::ACT_READ, 0, 0, 63);
        send_item(sbc_pkg::ACT_FINISH, 0, 0, 0);
    endtask

    task automatic test_directed_load();
        send_item(sbc_pkg::ACT_APPEND, 5, 0, 0);
        send_item(sbc_pkg::ACT_APPEND, 5, 4095, 0);
        send_item(sbc_pkg::ACT_APPEND, 5, 4095, 0);
        send_item(sbc_pkg::ACT_APPEND, 7, 64, 63);
        send_item(sbc_pkg::ACT_APPEND, 3, 1, 0);
        send_item(sbc_pkg::ACT_FINISH, 0, 0, 0);
        send_item(sbc_pkg::ACT_TEST, 5, 4095, 0);
        send_item(sbc_pkg::ACT_TEST, 5, 64, 0);
        send_item(sbc_pkg::ACT_TEST, 6, 0, 0);
        send_item(sbc_pkg::ACT_TEST, 7, 64, 0);
        send_item(sbc_pkg::ACT_ACCUM, 5, 0, 0);
        send_item(sbc_pkg::ACT_ACCUM, 7, 0, 0);
        send_item(sbc_pkg::ACT_READ, 0, 0, 0);
        send_item(sbc_pkg::ACT_READ, 0, 0, 0);
        send_item(sbc_pkg::ACT_READ, 0, 0, 63);
        send_item(sbc_pkg::ACT_READ, 0, 0, 1);
        send_item(3'd5, 4095, 4095, 63);
        send_item(3'd6, 0, 0, 0);
        send_item(3'd7, 4095, 4095, 63);
        send_item(sbc_pkg::ACT_APPEND, 7, 128, 0);
        send_item(sbc_pkg::ACT_TEST, 7, 128, 0);
        row_left = 0;
    endtask

    task automatic test_random_mix(int count);
        int i;
        int pick;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_append_run(1);
            else if (pick < 80)
                send_query();
            else if (pick < 85)
                send_item(sbc_pkg::ACT_FINISH, $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 63));
            else if (pick < 92 && last_row > 0)
                send_item(sbc_pkg::ACT_APPEND, $urandom_range(0, last_row - 1),
                          $urandom_range(0, 4095), $urandom_range(0, 63));
            else
                send_item(3'($urandom_range(5, 7)), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 63));
        end
    endtask

    task automatic test_store_full();
        while (rows_used < ROWS_CAP && entries_used < ENTRIES_CAP)
            send_item(sbc_pkg::ACT_APPEND, last_row + 1, $urandom_range(0, DIM - 1), 0);
        send_item(sbc_pkg::ACT_APPEND, last_row + 1, 9, 0);
        send_item(sbc_pkg::ACT_FINISH, 0, 0, 0);
        repeat (8)
            send_item(sbc_pkg::ACT_APPEND, last_row, $urandom_range(0, DIM - 1), 0);
        send_item(sbc_pkg::ACT_APPEND, last_row, 17, 0);
        send_item(sbc_pkg::ACT_APPEND, last_row + 1, 17, 0);
        send_item(sbc_pkg::ACT_FINISH, 0, 0, 0);
        send_item(sbc_pkg::ACT_TEST, last_row, shadow_cols[entries_used - 1], 0);
    endtask

    task automatic test_final_queries(int count);
        int i;
        for (i = 0; i < count; i++)
            send_query();
    endtask

    initial
    begin : sink_ready
        int stall;
        result_if.ready <= 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                result_if.ready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 11) - 1;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        matrix_result_t exp_res;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result hit=%0b data=%h status=%0d", $time,
                         result_if.hit, result_if.word_data, result_if.status);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (result_if.status == sbc_pkg::STAT_FULL)
                    full_drops++;
                if (result_if.status == sbc_pkg::STAT_ORDER)
                    order_drops++;
                if (result_if.hit)
                    hits_seen++;
                if (result_if.hit !== exp_res.hit)
                begin
                    errors++;
                    $display("%0t: hit expected %0b actual %0b", $time, exp_res.hit,
                             result_if.hit);
                end
                if (result_if.word_data !== exp_res.word_data)
                begin
                    errors++;
                    $display("%0t: word_data expected %h actual %h", $time,
                             exp_res.word_data, result_if.word_data);
                end
                if (result_if.status !== exp_res.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_res.status, result_if.status);
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.action = sbc_pkg::ACT_APPEND;
        item_if.row = '0;
        item_if.col = '0;
        item_if.word_index = '0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        full_drops = 0;
        order_drops = 0;
        hits_seen = 0;
        rows_used = 0;
        entries_used = 0;
        last_row = 0;
        have_last_row = 1'b0;
        row_left = 0;
        idle_enable = 1'b1;
        foreach (shadow_seen[i])
            shadow_seen[i] = 1'b0;
        foreach (shadow_bitmap[i])
            shadow_bitmap[i] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_matrix();
        test_directed_load();
        test_random_mix(700);
        test_store_full();
        idle_enable = 1'b0;
        test_final_queries(150);
        item_if.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        wait_cycles = 0;
        while (wait_cycles < 50)
        begin
            @(posedge clk);
            wait_cycles++;
        end

        $display("Sent %0d transactions, checked %0d results (%0d hits, %0d full, %0d order).",
                 items_sent, results_seen, hits_seen, full_drops, order_drops);
        $display("Matrix reached %0d rows and %0d entries.", rows_used, entries_used);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
